[design/rrts_pkg.sv]
// ----------------------------------------------------------------------------
// Round-robin thread scheduler: shared package
// Slot state codes, event and status codes, request and response types, and
// the constants for turning a sleep length in milliseconds into seconds.
// ----------------------------------------------------------------------------
`default_nettype none

package rrts_pkg;

   // Default sizes of the thread table
   localparam int SLOTS_DEF     = 16;
   localparam int ID_BITS_DEF   = 16;
   localparam int TIME_BITS_DEF = 32;

   // Slot state codes
   localparam int SLOT_ST_W = 3;
   localparam logic [SLOT_ST_W-1:0] ST_UNUSED   = 3'd0;
   localparam logic [SLOT_ST_W-1:0] ST_READY    = 3'd1;
   localparam logic [SLOT_ST_W-1:0] ST_RUNNING  = 3'd2;
   localparam logic [SLOT_ST_W-1:0] ST_SLEEPING = 3'd3;
   localparam logic [SLOT_ST_W-1:0] ST_BLOCKED  = 3'd4;
   localparam logic [SLOT_ST_W-1:0] ST_DEAD     = 3'd5;

   // Event codes
   localparam logic [2:0] CMD_CREATE  = 3'd0;
   localparam logic [2:0] CMD_YIELD   = 3'd1;
   localparam logic [2:0] CMD_SLEEP   = 3'd2;
   localparam logic [2:0] CMD_BLOCK   = 3'd3;
   localparam logic [2:0] CMD_UNBLOCK = 3'd4;
   localparam logic [2:0] CMD_EXIT    = 3'd5;
   localparam logic [2:0] CMD_TICK    = 3'd6;

   // Response status codes
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_NO_SLOT  = 2'd1;
   localparam logic [1:0] STAT_NO_STACK = 2'd2;

   // Milliseconds to seconds: floor(ms / 1000) = (ms * DIV1000_MUL) >> DIV1000_SHIFT
   // for every 32-bit ms
   localparam int               MS_PER_SEC    = 1000;
   localparam logic [28:0]      DIV1000_MUL   = 29'h10624DD3;
   localparam int               DIV1000_SHIFT = 38;
   localparam int               SECS_W        = 23;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [15:0] target_id;
      logic [31:0] sleep_ms;
      logic [31:0] now_seconds;
      logic        stack_granted;
   } rrts_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] created_id;
      logic [15:0] running_id;
      logic [3:0]  running_slot;
      logic        switched;
      logic [3:0]  previous_slot;
   } rrts_rsp_type;

endpackage

`default_nettype wire

[design/rrts_slot_ram.sv]
// ----------------------------------------------------------------------------
// Round-robin thread scheduler: slot table memory
// One write port and one read port with registered read data. A valid bit
// per entry makes unwritten entries read as their reset contents: slot 0
// running, all others unused, id and wake time zero.
// ----------------------------------------------------------------------------
`default_nettype none

module rrts_slot_ram import rrts_pkg::*; #(
   parameter int SLOTS     = SLOTS_DEF,
   parameter int ID_BITS   = ID_BITS_DEF,
   parameter int TIME_BITS = TIME_BITS_DEF,
   localparam int SLOT_BITS = $clog2(SLOTS)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 rd_en,
   input  wire logic [SLOT_BITS-1:0] rd_addr,
   output      logic [SLOT_ST_W-1:0] rd_status,
   output      logic [ID_BITS-1:0]   rd_id,
   output      logic [TIME_BITS-1:0] rd_wake,
   input  wire logic                 wr_en,
   input  wire logic [SLOT_BITS-1:0] wr_addr,
   input  wire logic [SLOT_ST_W-1:0] wr_status,
   input  wire logic [ID_BITS-1:0]   wr_id,
   input  wire logic [TIME_BITS-1:0] wr_wake
);

   localparam int ENTRY_W = SLOT_ST_W + ID_BITS + TIME_BITS;

   logic [ENTRY_W-1:0] mem [SLOTS];
   logic [SLOTS-1:0]   valid_ff;
   logic [ENTRY_W-1:0] rd_data_ff;
   logic               rd_valid_ff;
   logic               rd_zero_ff;

   // Write the entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_status, wr_id, wr_wake};
      end
   end

   // Register the read data with its valid bit
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff  <= mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
         rd_zero_ff  <= (rd_addr == '0);
      end
   end

   // Mark entries written since reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // Substitute reset contents for entries never written
   always_comb begin
      if (rd_valid_ff) begin
         rd_status = rd_data_ff[ENTRY_W-1 -: SLOT_ST_W];
         rd_id     = rd_data_ff[TIME_BITS +: ID_BITS];
         rd_wake   = rd_data_ff[TIME_BITS-1:0];
      end else begin
         rd_status = rd_zero_ff ? ST_RUNNING : ST_UNUSED;
         rd_id     = '0;
         rd_wake   = '0;
      end
   end

endmodule

`default_nettype wire

[design/round_robin_thread_scheduler.sv]
// ----------------------------------------------------------------------------
// Round-robin thread scheduler
// Thread table in a slot memory, walked by a pass sequencer for each event.
// ----------------------------------------------------------------------------
// An event is taken when start is high and busy is low. The block walks the
// slot memory through its single read port, one slot per cycle: one pass to
// find the free slot and the current and target threads, one pass to wake
// sleepers and find the next ready slot (scheduling events only), and one
// pass to find the running slot for the response. The response sits on
// rsp_item for the single cycle in which rsp_strobe is high, right after
// busy falls; it must be taken then, since it cannot be held off. A new
// event may start in that same cycle. The enable register may be written
// only while busy is low.
// ----------------------------------------------------------------------------
`default_nettype none

module round_robin_thread_scheduler import rrts_pkg::*; #(
   parameter int SLOTS     = SLOTS_DEF,
   parameter int ID_BITS   = ID_BITS_DEF,
   parameter int TIME_BITS = TIME_BITS_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output      logic         busy,
   input  wire rrts_req_type req_item,
   output      logic         rsp_strobe,
   output      rrts_rsp_type rsp_item,
   input  wire logic         csr_write_enable,
   input  wire logic         csr_write_data
);

   localparam int SLOT_BITS = $clog2(SLOTS);
   localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(SLOTS - 1);
   localparam int SUM_W  = TIME_BITS + SECS_W + 1;
   localparam int PROD_W = 32 + 29;

   // Sequencer states
   localparam logic [2:0] FSM_IDLE       = 3'd0;
   localparam logic [2:0] FSM_SCAN_A     = 3'd1;
   localparam logic [2:0] FSM_MODIFY     = 3'd2;
   localparam logic [2:0] FSM_SCAN_B     = 3'd3;
   localparam logic [2:0] FSM_COMMIT_OLD = 3'd4;
   localparam logic [2:0] FSM_COMMIT_NEW = 3'd5;
   localparam logic [2:0] FSM_SCAN_C     = 3'd6;
   localparam logic [2:0] FSM_FINISH     = 3'd7;

   // Control registers
   logic [2:0]           state_ff, state_in;
   logic                 enable_ff, enable_in;
   logic [ID_BITS-1:0]   cur_id_ff, cur_id_in;
   logic [ID_BITS-1:0]   id_ctr_ff, id_ctr_in;
   logic [SLOT_BITS-1:0] idx_ff, idx_in;
   logic                 issue_ff, issue_in;
   logic                 pend_ff, pend_in;
   logic                 strobe_ff, strobe_in;
   logic                 free_hit_ff, free_hit_in;
   logic                 live_hit_ff, live_hit_in;
   logic                 tgt_hit_ff, tgt_hit_in;
   logic                 lo_hit_ff, lo_hit_in;
   logic                 hi_hit_ff, hi_hit_in;
   logic                 cur_hit_ff, cur_hit_in;
   logic                 run_hit_ff, run_hit_in;
   logic                 sw_ff, sw_in;

   // Payload registers
   rrts_req_type         req_ff, req_in;
   logic [SLOT_BITS-1:0] pidx_ff, pidx_in;
   logic [SLOT_BITS-1:0] free_slot_ff, free_slot_in;
   logic [SLOT_BITS-1:0] live_slot_ff, live_slot_in;
   logic [TIME_BITS-1:0] live_wake_ff, live_wake_in;
   logic [SLOT_BITS-1:0] tgt_slot_ff, tgt_slot_in;
   logic [SLOT_ST_W-1:0] tgt_stat_ff, tgt_stat_in;
   logic [TIME_BITS-1:0] tgt_wake_ff, tgt_wake_in;
   logic [SLOT_BITS-1:0] lo_slot_ff, lo_slot_in;
   logic [ID_BITS-1:0]   lo_id_ff, lo_id_in;
   logic [TIME_BITS-1:0] lo_wake_ff, lo_wake_in;
   logic [SLOT_BITS-1:0] hi_slot_ff, hi_slot_in;
   logic [ID_BITS-1:0]   hi_id_ff, hi_id_in;
   logic [TIME_BITS-1:0] hi_wake_ff, hi_wake_in;
   logic [SLOT_BITS-1:0] cur_slot_ff, cur_slot_in;
   logic [TIME_BITS-1:0] cur_wake_ff, cur_wake_in;
   logic [SLOT_BITS-1:0] run_slot_ff, run_slot_in;
   logic [1:0]           stat_ff, stat_in;
   logic [ID_BITS-1:0]   created_ff, created_in;
   logic [SLOT_BITS-1:0] prev_ff, prev_in;
   logic [SECS_W-1:0]    q_ff, q_in;
   logic [SECS_W-1:0]    secs_ff, secs_in;
   rrts_rsp_type         rsp_ff, rsp_in;

   // Slot memory ports
   logic                 rd_en;
   logic [SLOT_BITS-1:0] rd_addr;
   logic [SLOT_ST_W-1:0] rd_status;
   logic [ID_BITS-1:0]   rd_id;
   logic [TIME_BITS-1:0] rd_wake;
   logic                 wr_en;
   logic [SLOT_BITS-1:0] wr_addr;
   logic [SLOT_ST_W-1:0] wr_status;
   logic [ID_BITS-1:0]   wr_id;
   logic [TIME_BITS-1:0] wr_wake;

   // Helpers
   logic                 last_rd;
   logic [ID_BITS-1:0]   tid;
   logic [TIME_BITS-1:0] now_t;
   logic                 due;
   logic [SLOT_ST_W-1:0] s_eff;
   logic                 nx_from_hi;
   logic                 nx_hit;
   logic [SLOT_BITS-1:0] nx_slot;
   logic [ID_BITS-1:0]   nx_id;
   logic [TIME_BITS-1:0] nx_wake;
   logic                 go;
   logic                 do_sched;
   logic [PROD_W-1:0]    prod;
   logic [31:0]          rem;
   logic [SECS_W-1:0]    secs_raw;
   logic [SUM_W-1:0]     wake_sum;

   rrts_slot_ram #(
      .SLOTS     (SLOTS),
      .ID_BITS   (ID_BITS),
      .TIME_BITS (TIME_BITS)
   ) u_slot_ram (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_status (rd_status),
      .rd_id     (rd_id),
      .rd_wake   (rd_wake),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_status (wr_status),
      .wr_id     (wr_id),
      .wr_wake   (wr_wake)
   );

   // Decode the held request and the returning slot
   assign tid     = ID_BITS'(req_ff.target_id);
   assign now_t   = TIME_BITS'(req_ff.now_seconds);
   assign last_rd = pend_ff && (pidx_ff == LAST_SLOT);
   assign due     = (rd_status == ST_SLEEPING) && (now_t >= rd_wake);
   assign s_eff   = due ? ST_READY : rd_status;

   // Pick the next ready slot: first one after the current slot, else lowest
   assign nx_from_hi = live_hit_ff && hi_hit_ff;
   assign nx_hit     = nx_from_hi || lo_hit_ff;
   assign nx_slot    = nx_from_hi ? hi_slot_ff : lo_slot_ff;
   assign nx_id      = nx_from_hi ? hi_id_ff : lo_id_ff;
   assign nx_wake    = nx_from_hi ? hi_wake_ff : lo_wake_ff;
   assign go         = nx_hit && !(cur_hit_ff && (cur_slot_ff == nx_slot));

   // Sleep length: ceiling of ms / 1000, at least one second
   assign prod     = PROD_W'(req_ff.sleep_ms) * PROD_W'(DIV1000_MUL);
   assign q_in     = prod[DIV1000_SHIFT +: SECS_W];
   assign rem      = req_ff.sleep_ms - (32'(q_ff) * 32'(MS_PER_SEC));
   assign secs_raw = q_ff + SECS_W'(rem != 32'd0);
   assign secs_in  = (secs_raw == '0) ? SECS_W'(1) : secs_raw;
   assign wake_sum = SUM_W'(now_t) + SUM_W'(secs_ff);

   assign do_sched = enable_ff &&
                     ((req_ff.cmd == CMD_YIELD) || (req_ff.cmd == CMD_TICK) ||
                      (req_ff.cmd == CMD_EXIT) ||
                      (((req_ff.cmd == CMD_SLEEP) || (req_ff.cmd == CMD_BLOCK)) &&
                       live_hit_ff));

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      enable_in    = csr_write_enable ? csr_write_data : enable_ff;
      cur_id_in    = cur_id_ff;
      id_ctr_in    = id_ctr_ff;
      idx_in       = idx_ff;
      issue_in     = issue_ff;
      pend_in      = issue_ff;
      pidx_in      = idx_ff;
      strobe_in    = 1'b0;
      free_hit_in  = free_hit_ff;
      live_hit_in  = live_hit_ff;
      tgt_hit_in   = tgt_hit_ff;
      lo_hit_in    = lo_hit_ff;
      hi_hit_in    = hi_hit_ff;
      cur_hit_in   = cur_hit_ff;
      run_hit_in   = run_hit_ff;
      sw_in        = sw_ff;
      req_in       = req_ff;
      free_slot_in = free_slot_ff;
      live_slot_in = live_slot_ff;
      live_wake_in = live_wake_ff;
      tgt_slot_in  = tgt_slot_ff;
      tgt_stat_in  = tgt_stat_ff;
      tgt_wake_in  = tgt_wake_ff;
      lo_slot_in   = lo_slot_ff;
      lo_id_in     = lo_id_ff;
      lo_wake_in   = lo_wake_ff;
      hi_slot_in   = hi_slot_ff;
      hi_id_in     = hi_id_ff;
      hi_wake_in   = hi_wake_ff;
      cur_slot_in  = cur_slot_ff;
      cur_wake_in  = cur_wake_ff;
      run_slot_in  = run_slot_ff;
      stat_in      = stat_ff;
      created_in   = created_ff;
      prev_in      = prev_ff;
      rsp_in       = rsp_ff;
      rd_en        = issue_ff;
      rd_addr      = idx_ff;
      wr_en        = 1'b0;
      wr_addr      = pidx_ff;
      wr_status    = rd_status;
      wr_id        = rd_id;
      wr_wake      = rd_wake;

      // Advance the read address through the table
      if (issue_ff) begin
         if (idx_ff == LAST_SLOT) begin
            issue_in = 1'b0;
         end else begin
            idx_in = idx_ff + SLOT_BITS'(1);
         end
      end

      unique case (state_ff)
         FSM_IDLE: begin
            if (start) begin
               req_in      = req_item;
               free_hit_in = 1'b0;
               live_hit_in = 1'b0;
               tgt_hit_in  = 1'b0;
               lo_hit_in   = 1'b0;
               hi_hit_in   = 1'b0;
               cur_hit_in  = 1'b0;
               run_hit_in  = 1'b0;
               sw_in       = 1'b0;
               stat_in     = STAT_OK;
               created_in  = '0;
               prev_in     = '0;
               idx_in      = '0;
               issue_in    = 1'b1;
               state_in    = FSM_SCAN_A;
            end
         end

         // Find the free slot, the current thread and the unblock target
         FSM_SCAN_A: begin
            if (pend_ff) begin
               if (!free_hit_ff && (rd_status == ST_UNUSED)) begin
                  free_hit_in  = 1'b1;
                  free_slot_in = pidx_ff;
               end
               if (!live_hit_ff && (rd_status != ST_UNUSED) && (rd_id == cur_id_ff)) begin
                  live_hit_in  = 1'b1;
                  live_slot_in = pidx_ff;
                  live_wake_in = rd_wake;
               end
               if (!tgt_hit_ff && (rd_status != ST_UNUSED) && (rd_id == tid)) begin
                  tgt_hit_in  = 1'b1;
                  tgt_slot_in = pidx_ff;
                  tgt_stat_in = rd_status;
                  tgt_wake_in = rd_wake;
               end
            end
            if (last_rd) begin
               state_in = FSM_MODIFY;
            end
         end

         // Apply the event to at most one slot, then start the next pass
         FSM_MODIFY: begin
            unique case (req_ff.cmd) inside
               CMD_CREATE: begin
                  if (!free_hit_ff) begin
                     stat_in = STAT_NO_SLOT;
                  end else if (!req_ff.stack_granted) begin
                     stat_in = STAT_NO_STACK;
                  end else begin
                     wr_en      = 1'b1;
                     wr_addr    = free_slot_ff;
                     wr_status  = ST_READY;
                     wr_id      = id_ctr_ff;
                     wr_wake    = '0;
                     created_in = id_ctr_ff;
                     id_ctr_in  = id_ctr_ff + ID_BITS'(1);
                  end
               end
               CMD_SLEEP: begin
                  wr_en     = live_hit_ff;
                  wr_addr   = live_slot_ff;
                  wr_status = ST_SLEEPING;
                  wr_id     = cur_id_ff;
                  wr_wake   = wake_sum[TIME_BITS-1:0];
               end
               CMD_BLOCK: begin
                  wr_en     = live_hit_ff;
                  wr_addr   = live_slot_ff;
                  wr_status = ST_BLOCKED;
                  wr_id     = cur_id_ff;
                  wr_wake   = live_wake_ff;
               end
               CMD_EXIT: begin
                  wr_en     = live_hit_ff;
                  wr_addr   = live_slot_ff;
                  wr_status = ST_DEAD;
                  wr_id     = cur_id_ff;
                  wr_wake   = live_wake_ff;
               end
               CMD_UNBLOCK: begin
                  wr_en     = tgt_hit_ff && (tgt_stat_ff == ST_BLOCKED);
                  wr_addr   = tgt_slot_ff;
                  wr_status = ST_READY;
                  wr_id     = tid;
                  wr_wake   = tgt_wake_ff;
               end
               CMD_YIELD, CMD_TICK: begin
                  wr_en = 1'b0;
               end
               default: begin
                  wr_en = 1'b0;
               end
            endcase
            idx_in   = '0;
            issue_in = 1'b1;
            state_in = do_sched ? FSM_SCAN_B : FSM_SCAN_C;
         end

         // Wake due sleepers and collect the ready and running candidates
         FSM_SCAN_B: begin
            if (pend_ff) begin
               if (due) begin
                  wr_en     = 1'b1;
                  wr_status = ST_READY;
               end
               if (!lo_hit_ff && (s_eff == ST_READY)) begin
                  lo_hit_in  = 1'b1;
                  lo_slot_in = pidx_ff;
                  lo_id_in   = rd_id;
                  lo_wake_in = rd_wake;
               end
               if (!hi_hit_ff && (s_eff == ST_READY) && (pidx_ff > live_slot_ff)) begin
                  hi_hit_in  = 1'b1;
                  hi_slot_in = pidx_ff;
                  hi_id_in   = rd_id;
                  hi_wake_in = rd_wake;
               end
               if (!cur_hit_ff && (s_eff == ST_RUNNING) && (rd_id == cur_id_ff)) begin
                  cur_hit_in  = 1'b1;
                  cur_slot_in = pidx_ff;
                  cur_wake_in = rd_wake;
               end
            end
            if (last_rd) begin
               state_in = FSM_COMMIT_OLD;
            end
         end

         // Return the old running slot to ready
         FSM_COMMIT_OLD: begin
            if (go && cur_hit_ff) begin
               wr_en     = 1'b1;
               wr_addr   = cur_slot_ff;
               wr_status = ST_READY;
               wr_id     = cur_id_ff;
               wr_wake   = cur_wake_ff;
               sw_in     = 1'b1;
               prev_in   = cur_slot_ff;
            end
            state_in = FSM_COMMIT_NEW;
         end

         // Hand the running mark to the chosen slot
         FSM_COMMIT_NEW: begin
            if (go) begin
               wr_en     = 1'b1;
               wr_addr   = nx_slot;
               wr_status = ST_RUNNING;
               wr_id     = nx_id;
               wr_wake   = nx_wake;
               cur_id_in = nx_id;
            end
            idx_in   = '0;
            issue_in = 1'b1;
            state_in = FSM_SCAN_C;
         end

         // Find the running slot of the current thread
         FSM_SCAN_C: begin
            if (pend_ff && !run_hit_ff && (rd_status == ST_RUNNING) && (rd_id == cur_id_ff)) begin
               run_hit_in  = 1'b1;
               run_slot_in = pidx_ff;
            end
            if (last_rd) begin
               state_in = FSM_FINISH;
            end
         end

         // Load the response
         FSM_FINISH: begin
            rsp_in.status        = stat_ff;
            rsp_in.created_id    = 16'(created_ff);
            rsp_in.running_id    = 16'(cur_id_ff);
            rsp_in.running_slot  = run_hit_ff ? 4'(run_slot_ff) : 4'd0;
            rsp_in.switched      = sw_ff;
            rsp_in.previous_slot = 4'(prev_ff);
            strobe_in            = 1'b1;
            state_in             = FSM_IDLE;
         end

         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= FSM_IDLE;
         enable_ff   <= 1'b1;
         cur_id_ff   <= '0;
         id_ctr_ff   <= ID_BITS'(1);
         idx_ff      <= '0;
         issue_ff    <= 1'b0;
         pend_ff     <= 1'b0;
         strobe_ff   <= 1'b0;
         free_hit_ff <= 1'b0;
         live_hit_ff <= 1'b0;
         tgt_hit_ff  <= 1'b0;
         lo_hit_ff   <= 1'b0;
         hi_hit_ff   <= 1'b0;
         cur_hit_ff  <= 1'b0;
         run_hit_ff  <= 1'b0;
         sw_ff       <= 1'b0;
      end else begin
         state_ff    <= state_in;
         enable_ff   <= enable_in;
         cur_id_ff   <= cur_id_in;
         id_ctr_ff   <= id_ctr_in;
         idx_ff      <= idx_in;
         issue_ff    <= issue_in;
         pend_ff     <= pend_in;
         strobe_ff   <= strobe_in;
         free_hit_ff <= free_hit_in;
         live_hit_ff <= live_hit_in;
         tgt_hit_ff  <= tgt_hit_in;
         lo_hit_ff   <= lo_hit_in;
         hi_hit_ff   <= hi_hit_in;
         cur_hit_ff  <= cur_hit_in;
         run_hit_ff  <= run_hit_in;
         sw_ff       <= sw_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      pidx_ff      <= pidx_in;
      free_slot_ff <= free_slot_in;
      live_slot_ff <= live_slot_in;
      live_wake_ff <= live_wake_in;
      tgt_slot_ff  <= tgt_slot_in;
      tgt_stat_ff  <= tgt_stat_in;
      tgt_wake_ff  <= tgt_wake_in;
      lo_slot_ff   <= lo_slot_in;
      lo_id_ff     <= lo_id_in;
      lo_wake_ff   <= lo_wake_in;
      hi_slot_ff   <= hi_slot_in;
      hi_id_ff     <= hi_id_in;
      hi_wake_ff   <= hi_wake_in;
      cur_slot_ff  <= cur_slot_in;
      cur_wake_ff  <= cur_wake_in;
      run_slot_ff  <= run_slot_in;
      stat_ff      <= stat_in;
      created_ff   <= created_in;
      prev_ff      <= prev_in;
      q_ff         <= q_in;
      secs_ff      <= secs_in;
      rsp_ff       <= rsp_in;
   end

   assign busy       = (state_ff != FSM_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

   // A response comes only out of the finishing step
   a_strobe_from_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff) == FSM_FINISH)
      else $error("response strobe without a finished request");

   // A write-back never hits the slot being read in the same cycle
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      (rd_en && wr_en) |-> (rd_addr != wr_addr))
      else $error("slot memory read and write to the same entry");

   // After a switch the new thread must be found running
   a_switch_has_runner: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == FSM_FINISH) && sw_ff) |-> run_hit_ff)
      else $error("switch left no running slot");

   // Every request ends with exactly its response
   a_busy_ends_with_rsp: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_strobe)
      else $error("busy dropped without a response");

endmodule

`default_nettype wire
